// ===== rtl/crc_pkg.sv =====
// ----------------------------------------------------------------------------
// crc_pkg: shared types and constants
// Widths and pipeline payload structures used by the circle/rectangle
// collision pipeline.
// ----------------------------------------------------------------------------
package crc_pkg;

	localparam int RAD_W     = 16;  // radius width
	localparam int MAG_W     = 16;  // axis distance width that can still hit
	localparam int D2_W      = 33;  // squared distance width
	localparam int NORM_SH   = 28;  // squared distance is scaled by 2^28
	localparam int SQ_IN_W   = 62;  // square root operand width (even)
	localparam int Q_W       = SQ_IN_W / 2;
	localparam int NUM_W     = 45;  // divider numerator width
	localparam int QUO_W     = 15;  // quotient bits, enough for 16385
	localparam int DEPTH_W   = 17;
	localparam int NRM_W     = 16;
	localparam logic [QUO_W-1:0] NRM_ONE = 15'd16384;

	typedef struct packed {
		logic               hit;
		logic               degen;
		logic [RAD_W-1:0]   r;
		logic               sx;
		logic               sy;
		logic [MAG_W-1:0]   ax;
		logic [MAG_W-1:0]   ay;
		logic [D2_W-1:0]    d2;
	} front_t;

	typedef struct packed {
		logic               hit;
		logic               degen;
		logic [RAD_W-1:0]   r;
		logic               sx;
		logic               sy;
		logic [MAG_W-1:0]   ax;
		logic [MAG_W-1:0]   ay;
	} sq_pay_t;

	typedef struct packed {
		logic               hit;
		logic               degen;
		logic [DEPTH_W-1:0] depth;
		logic               sx;
		logic               sy;
	} div_pay_t;

endpackage

// ===== rtl/crc_front.sv =====
// ----------------------------------------------------------------------------
// crc_front: closest point and squared distance
// Five stages: edges, clamp offset, magnitude, squares, sum and overlap test.
// ----------------------------------------------------------------------------
module crc_front #(
	parameter int COORD_FRAC_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic signed [23:0] center_x,
	input  logic signed [23:0] center_y,
	input  logic [15:0]        radius_len,
	input  logic signed [15:0] box_left,
	input  logic signed [15:0] box_top,
	input  logic [14:0]        box_width,
	input  logic [14:0]        box_height,
	output logic               out_vld,
	output crc_pkg::front_t    out_data
);
	import crc_pkg::*;

	localparam int BW = 17 + COORD_FRAC_BITS;
	localparam int CW = ((BW > 24) ? BW : 24) + 1;
	localparam int DW = CW + 1;

	logic [4:0] vld_s;

	logic signed [CW-1:0] cx_s1, cy_s1, lft_s1, rgt_s1, top_s1, bot_s1;
	logic [RAD_W-1:0]     r_s1, r_s2, r_s3, r_s4;
	logic signed [DW-1:0] dx_s2, dy_s2;
	logic [MAG_W-1:0]     ax_s3, ay_s3, ax_s4, ay_s4;
	logic                 sx_s3, sy_s3, big_s3, sx_s4, sy_s4, big_s4;
	logic [2*MAG_W-1:0]   sqx_s4, sqy_s4, rr_s4;
	front_t               res_s5;

	logic signed [CW-1:0] lft, tp, cxc, cyc;
	logic [DW-1:0]        mx, my;
	logic [D2_W-1:0]      d2;
	logic                 hit;

	always_comb begin
		lft = CW'(box_left) <<< COORD_FRAC_BITS;
		tp  = CW'(box_top) <<< COORD_FRAC_BITS;
		if (cx_s1 < lft_s1) cxc = lft_s1;
		else if (cx_s1 > rgt_s1) cxc = rgt_s1;
		else cxc = cx_s1;
		if (cy_s1 < top_s1) cyc = top_s1;
		else if (cy_s1 > bot_s1) cyc = bot_s1;
		else cyc = cy_s1;
		mx = dx_s2[DW-1] ? DW'(-dx_s2) : DW'(dx_s2);
		my = dy_s2[DW-1] ? DW'(-dy_s2) : DW'(dy_s2);
		d2  = D2_W'(sqx_s4) + D2_W'(sqy_s4);
		hit = !big_s4 && (d2 < D2_W'(rr_s4));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[3:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1  <= CW'(center_x);
			cy_s1  <= CW'(center_y);
			lft_s1 <= lft;
			rgt_s1 <= lft + (CW'({1'b0, box_width}) <<< COORD_FRAC_BITS);
			top_s1 <= tp;
			bot_s1 <= tp + (CW'({1'b0, box_height}) <<< COORD_FRAC_BITS);
			r_s1   <= radius_len;

			dx_s2 <= DW'(cxc) - DW'(cx_s1);
			dy_s2 <= DW'(cyc) - DW'(cy_s1);
			r_s2  <= r_s1;

			ax_s3  <= mx[MAG_W-1:0];
			ay_s3  <= my[MAG_W-1:0];
			big_s3 <= (|mx[DW-1:MAG_W]) || (|my[DW-1:MAG_W]);
			sx_s3  <= dx_s2[DW-1];
			sy_s3  <= dy_s2[DW-1];
			r_s3   <= r_s2;

			sqx_s4 <= ax_s3 * ax_s3;
			sqy_s4 <= ay_s3 * ay_s3;
			rr_s4  <= r_s3 * r_s3;
			ax_s4  <= ax_s3;
			ay_s4  <= ay_s3;
			sx_s4  <= sx_s3;
			sy_s4  <= sy_s3;
			big_s4 <= big_s3;
			r_s4   <= r_s3;

			res_s5.hit   <= hit;
			res_s5.degen <= hit && (d2 == '0);
			res_s5.r     <= r_s4;
			res_s5.sx    <= sx_s4;
			res_s5.sy    <= sy_s4;
			res_s5.ax    <= ax_s4;
			res_s5.ay    <= ay_s4;
			res_s5.d2    <= d2;
		end
	end

	assign out_vld  = vld_s[4];
	assign out_data = res_s5;

endmodule

// ===== rtl/crc_isqrt.sv =====
// ----------------------------------------------------------------------------
// crc_isqrt: pipelined integer square root
// One result bit per stage, digit by digit, with a payload carried alongside.
// ----------------------------------------------------------------------------
module crc_isqrt #(
	parameter int IW = 62,
	parameter int PW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  logic [IW-1:0]   in_val,
	input  logic [PW-1:0]   in_pay,
	output logic            out_vld,
	output logic [IW/2-1:0] out_root,
	output logic [PW-1:0]   out_pay
);
	localparam int NS = IW / 2;
	localparam int OW = IW / 2;
	localparam int RW = OW + 3;

	logic          vld_s  [NS];
	logic [RW-1:0] rem_s  [NS];
	logic [OW-1:0] root_s [NS];
	logic [IW-1:0] val_s  [NS];
	logic [PW-1:0] pay_s  [NS];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic          p_vld;
		logic [RW-1:0] p_rem, cur, trial;
		logic [OW-1:0] p_root;
		logic [IW-1:0] p_val;
		logic [PW-1:0] p_pay;
		logic          take;

		always_comb begin
			if (k == 0) begin
				p_vld  = in_vld;
				p_rem  = '0;
				p_root = '0;
				p_val  = in_val;
				p_pay  = in_pay;
			end else begin
				p_vld  = vld_s[k-1];
				p_rem  = rem_s[k-1];
				p_root = root_s[k-1];
				p_val  = val_s[k-1];
				p_pay  = pay_s[k-1];
			end
			cur   = {p_rem[RW-3:0], p_val[IW-1:IW-2]};
			trial = RW'({p_root, 2'b01});
			take  = (cur >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? (cur - trial) : cur;
				root_s[k] <= {p_root[OW-2:0], take};
				val_s[k]  <= p_val << 2;
				pay_s[k]  <= p_pay;
			end
		end
	end

	assign out_vld  = vld_s[NS-1];
	assign out_root = root_s[NS-1];
	assign out_pay  = pay_s[NS-1];

endmodule

// ===== rtl/crc_div.sv =====
// ----------------------------------------------------------------------------
// crc_div: rounded depth and pipelined normal division
// A setup stage forms the rounded distance and both numerators, then two
// restoring divider lanes produce one quotient bit per stage.
// ----------------------------------------------------------------------------
module crc_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic [crc_pkg::Q_W-1:0] in_q,
	input  crc_pkg::sq_pay_t      in_pay,
	output logic                  out_vld,
	output logic [crc_pkg::QUO_W-1:0] out_qx,
	output logic [crc_pkg::QUO_W-1:0] out_qy,
	output crc_pkg::div_pay_t     out_pay
);
	import crc_pkg::*;

	localparam int SW = Q_W - 14 + 1;

	logic             vld_s0;
	logic [Q_W-1:0]   q_s0;
	logic [NUM_W-1:0] nx_s0, ny_s0;
	div_pay_t         pay_s0;

	logic             vld_s  [QUO_W];
	logic [Q_W-1:0]   q_s    [QUO_W];
	logic [NUM_W-1:0] rx_s   [QUO_W];
	logic [NUM_W-1:0] ry_s   [QUO_W];
	logic [QUO_W-1:0] qx_s   [QUO_W];
	logic [QUO_W-1:0] qy_s   [QUO_W];
	div_pay_t         pay_s  [QUO_W];

	logic [SW-1:0] rnd_dist;
	logic [SW:0]   dep;

	always_comb begin
		// Rounded distance: bit 13 of the scaled root is the half bit.
		rnd_dist = SW'(in_q[Q_W-1:14]) + SW'(in_q[13]);
		dep      = (SW+1)'(rnd_dist) - (SW+1)'(in_pay.r);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s0         <= in_q;
			nx_s0        <= (NUM_W'(in_pay.ax) << NORM_SH) + NUM_W'(in_q >> 1);
			ny_s0        <= (NUM_W'(in_pay.ay) << NORM_SH) + NUM_W'(in_q >> 1);
			pay_s0.hit   <= in_pay.hit;
			pay_s0.degen <= in_pay.degen;
			pay_s0.depth <= dep[DEPTH_W-1:0];
			pay_s0.sx    <= in_pay.sx;
			pay_s0.sy    <= in_pay.sy;
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic             p_vld;
		logic [Q_W-1:0]   p_q;
		logic [NUM_W-1:0] p_rx, p_ry, dsh;
		logic [QUO_W-1:0] p_qx, p_qy;
		div_pay_t         p_pay;
		logic             tx, ty;

		always_comb begin
			if (k == 0) begin
				p_vld = vld_s0;
				p_q   = q_s0;
				p_rx  = nx_s0;
				p_ry  = ny_s0;
				p_qx  = '0;
				p_qy  = '0;
				p_pay = pay_s0;
			end else begin
				p_vld = vld_s[k-1];
				p_q   = q_s[k-1];
				p_rx  = rx_s[k-1];
				p_ry  = ry_s[k-1];
				p_qx  = qx_s[k-1];
				p_qy  = qy_s[k-1];
				p_pay = pay_s[k-1];
			end
			dsh = NUM_W'(p_q) << (QUO_W - 1 - k);
			tx  = (p_rx >= dsh);
			ty  = (p_ry >= dsh);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k]   <= p_q;
				rx_s[k]  <= tx ? (p_rx - dsh) : p_rx;
				ry_s[k]  <= ty ? (p_ry - dsh) : p_ry;
				qx_s[k]  <= {p_qx[QUO_W-2:0], tx};
				qy_s[k]  <= {p_qy[QUO_W-2:0], ty};
				pay_s[k] <= p_pay;
			end
		end
	end

	assign out_vld = vld_s[QUO_W-1];
	assign out_qx  = qx_s[QUO_W-1];
	assign out_qy  = qy_s[QUO_W-1];
	assign out_pay = pay_s[QUO_W-1];

endmodule

// ===== rtl/circle_rect_collision.sv =====
// ----------------------------------------------------------------------------
// circle_rect_collision: circle against axis-aligned rectangle
// Finds the closest rectangle point to a circle centre, tests overlap and
// reports penetration depth and the unit normal toward the closest point.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Transaction contents
//  --------+-----------+------------------------------------------------------
//  s_*     | in        | one query: circle centre, radius and rectangle
//  m_*     | out       | one result: hit, degenerate, depth and unit normal
//
// Every query produces exactly one result, after it has passed through
// 5 front stages, 31 square root stages, 16 divider stages and one output
// register. The pipeline accepts one query per cycle while results drain.
// All stages advance together: the pipeline moves whenever the output
// register is empty or its result is taken, so a stall at m_tready holds
// every stage in place. Reset clears only the valid bits.
//
module circle_rect_collision #(
	parameter int COORD_FRAC_BITS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [23:0] center_x, [47:24] center_y, [63:48] radius_len,
	// [79:64] box_left, [95:80] box_top, [110:96] box_width,
	// [125:111] box_height, [127:126] zero
	input  logic [127:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [16:0] depth, [32:17] normal_x, [48:33] normal_y, [55:49] zero
	output logic [55:0]  m_tdata,
	// [0] hit, [1] degenerate
	output logic [1:0]   m_tuser
);
	import crc_pkg::*;

	logic en;

	// The whole pipeline shares one advance enable.
	assign en       = m_tready || !m_tvalid;
	assign s_tready = en;

	logic   f_vld;
	front_t f_data;

	crc_front #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_vld     (s_tvalid),
		.center_x   (s_tdata[23:0]),
		.center_y   (s_tdata[47:24]),
		.radius_len (s_tdata[63:48]),
		.box_left   (s_tdata[79:64]),
		.box_top    (s_tdata[95:80]),
		.box_width  (s_tdata[110:96]),
		.box_height (s_tdata[125:111]),
		.out_vld    (f_vld),
		.out_data   (f_data)
	);

	// The root of d2 * 2^28 gives the normal divisor, and its upper bits
	// give the distance itself along with the rounding bit.
	sq_pay_t          sq_in_pay, sq_out_pay;
	logic [Q_W-1:0]   sq_root;
	logic             sq_vld;

	assign sq_in_pay.hit   = f_data.hit;
	assign sq_in_pay.degen = f_data.degen;
	assign sq_in_pay.r     = f_data.r;
	assign sq_in_pay.sx    = f_data.sx;
	assign sq_in_pay.sy    = f_data.sy;
	assign sq_in_pay.ax    = f_data.ax;
	assign sq_in_pay.ay    = f_data.ay;

	crc_isqrt #(
		.IW(SQ_IN_W),
		.PW($bits(sq_pay_t))
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (f_vld),
		.in_val   ({(SQ_IN_W - D2_W - NORM_SH)'(0), f_data.d2, NORM_SH'(0)}),
		.in_pay   (sq_in_pay),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_pay  (sq_out_pay)
	);

	logic             dv_vld;
	logic [QUO_W-1:0] dv_qx, dv_qy;
	div_pay_t         dv_pay;

	crc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (sq_vld),
		.in_q    (sq_root),
		.in_pay  (sq_out_pay),
		.out_vld (dv_vld),
		.out_qx  (dv_qx),
		.out_qy  (dv_qy),
		.out_pay (dv_pay)
	);

	// Output formatting: clamp the quotient to one, apply the sign and
	// force the normal to zero when there is no hit or the centre sits on
	// the closest point.
	logic [QUO_W-1:0] mx, my;
	logic [NRM_W-1:0] nx, ny;
	logic             nrm_ok;
	logic             vld_q;
	logic [55:0]      data_q;
	logic [1:0]       user_q;

	always_comb begin
		mx     = (dv_qx > NRM_ONE) ? NRM_ONE : dv_qx;
		my     = (dv_qy > NRM_ONE) ? NRM_ONE : dv_qy;
		nrm_ok = dv_pay.hit && !dv_pay.degen;
		nx     = dv_pay.sx ? -NRM_W'(mx) : NRM_W'(mx);
		ny     = dv_pay.sy ? -NRM_W'(my) : NRM_W'(my);
		if (!nrm_ok) begin
			nx = '0;
			ny = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= {7'd0, ny, nx, dv_pay.hit ? dv_pay.depth : DEPTH_W'(0)};
			user_q <= {dv_pay.degen, dv_pay.hit};
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;

endmodule

// ===== rtl/crc_checker.sv =====
// ----------------------------------------------------------------------------
// crc_checker: port-level checks for circle_rect_collision
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
module crc_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [127:0] s_tdata,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [55:0]  m_tdata,
	input logic [1:0]   m_tuser
);

	// A result that is not taken holds its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Input is taken exactly when the output can move.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (m_tready || !m_tvalid))
		else $error("input ready does not follow output state");

	// A miss carries all-zero data.
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[48:0] == 49'd0 && !m_tuser[1])
		else $error("miss with nonzero fields");

	// A degenerate hit has a zero normal.
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0] && m_tdata[48:17] == 32'd0)
		else $error("degenerate result with a normal");

	// Depth is never positive.
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[16] || m_tdata[16:0] == 17'd0)
		else $error("positive depth");

endmodule

bind circle_rect_collision crc_checker u_crc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== bench/tb_circle_rect_collision.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circle_rect_collision: self-checking bench for the collision pipeline
// Drives circle/rectangle queries through the stream input, predicts every
// result with an independent integer model and compares field by field.
// ----------------------------------------------------------------------------
module tb_circle_rect_collision;

	localparam int FRAC      = 8;
	localparam int N_RANDOM  = 1500;
	localparam int LATENCY   = 53;
	localparam longint LIMIT = 400000;

	// One collision query and the result it should produce.
	typedef struct packed {
		logic [14:0] h;
		logic [14:0] w;
		logic [15:0] top;
		logic [15:0] left;
		logic [15:0] r;
		logic [23:0] cy;
		logic [23:0] cx;
	} query_t;

	typedef struct packed {
		logic        hit;
		logic        degen;
		logic [16:0] depth;
		logic [15:0] nx;
		logic [15:0] ny;
	} outcome_t;

	// Directed row: a query and, where obvious, its expected result.
	typedef struct {
		query_t   q;
		bit       typed;
		outcome_t want;
	} row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [55:0]  m_tdata;
	logic [1:0]   m_tuser;

	outcome_t pending_results[$];
	int       error_count = 0;
	int       results_seen = 0;
	int       hits_seen = 0;
	int       degen_seen = 0;
	longint   cycle_count = 0;
	bit       hold_long = 1'b0;
	bit       hold_done = 1'b0;

	always #5 clk = ~clk;

	circle_rect_collision #(.COORD_FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// Integer square root, floor, by bitwise restoring method.
	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root;
	endfunction

	// One normal component: rounded dx/len in Q1.14, saturated at one.
	function automatic logic [15:0] unit_component(input longint d,
			input longint unsigned q);
		longint unsigned m;
		longint unsigned quo;
		m = (d < 0) ? -d : d;
		quo = ((m << 28) + (q >> 1)) / q;
		if (quo > 16384)
			quo = 16384;
		return (d < 0) ? 16'(-longint'(quo)) : 16'(quo);
	endfunction

	function automatic outcome_t collide(input query_t q);
		outcome_t o;
		longint cx, cy, lft, tp, rgt, bot, px, py, dx, dy, dep;
		longint unsigned r, d2, s, q2;
		cx  = longint'($signed(q.cx));
		cy  = longint'($signed(q.cy));
		r   = q.r;
		lft = longint'($signed(q.left)) <<< FRAC;
		tp  = longint'($signed(q.top)) <<< FRAC;
		rgt = lft + (longint'(q.w) <<< FRAC);
		bot = tp + (longint'(q.h) <<< FRAC);
		px  = (cx < lft) ? lft : (cx > rgt) ? rgt : cx;
		py  = (cy < tp) ? tp : (cy > bot) ? bot : cy;
		dx  = px - cx;
		dy  = py - cy;
		d2  = dx * dx + dy * dy;
		o = '{default: '0};
		if (d2 < r * r) begin
			o.hit = 1'b1;
			s = floor_sqrt(d2);
			// Round the distance to nearest.
			if (d2 - s * s > s)
				s++;
			dep = longint'(s) - longint'(r);
			o.depth = dep[16:0];
			if (d2 == 0) begin
				o.degen = 1'b1;
			end else begin
				q2 = floor_sqrt(d2 << 28);
				o.nx = unit_component(dx, q2);
				o.ny = unit_component(dy, q2);
			end
		end
		return o;
	endfunction

	function automatic query_t make_query(input int cx, input int cy, input int r,
			input int l, input int t, input int w, input int h);
		query_t q;
		q.cx = cx[23:0]; q.cy = cy[23:0]; q.r = r[15:0];
		q.left = l[15:0]; q.top = t[15:0]; q.w = w[14:0]; q.h = h[14:0];
		return q;
	endfunction

	// Random query: mostly circles placed near a small box so that hits,
	// edge contacts and corner normals are common; the rest is raw noise.
	function automatic query_t random_query();
		query_t q;
		int sel, l, t, w, h, span;
		sel = $urandom_range(0, 9);
		if (sel < 2) begin
			q = 126'({$urandom, $urandom, $urandom, $urandom});
			return q;
		end
		l = $urandom_range(0, 65535) - 32768;
		t = $urandom_range(0, 65535) - 32768;
		if (sel < 4) begin
			l = $urandom_range(0, 200) - 100;
			t = $urandom_range(0, 200) - 100;
		end
		w = (sel == 9) ? $urandom_range(0, 32767) : $urandom_range(0, 64);
		h = (sel == 8) ? $urandom_range(0, 32767) : $urandom_range(0, 64);
		span = (sel == 7) ? 65535 : $urandom_range(1, 20000);
		q.r = (sel == 6) ? 16'($urandom) : 16'($urandom_range(0, span));
		q.cx = 24'((l << FRAC) + $urandom_range(0, (w << FRAC) + 2 * span) - span);
		q.cy = 24'((t << FRAC) + $urandom_range(0, (h << FRAC) + 2 * span) - span);
		q.left = l[15:0]; q.top = t[15:0]; q.w = w[14:0]; q.h = h[14:0];
		return q;
	endfunction

	// Offer one transaction, with a random gap in front of it.
	task automatic send_query(input query_t q);
		int gap;
		gap = ($urandom_range(0, 9) < 7) ? 0 : ($urandom_range(0, 19) == 0 ?
			$urandom_range(10, 60) : $urandom_range(1, 3));
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, q};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(collide(q));
	endtask

	// Receiver: random stalls, plus one long hold-off requested by the sender.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_long && !hold_done) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_done = 1'b1;
			end
			stall = ($urandom_range(0, 9) < 7) ? 0 : ($urandom_range(0, 19) == 0 ?
				$urandom_range(10, 80) : $urandom_range(1, 3));
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall - 1) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Result checker: every accepted result is matched against the oldest
	// outstanding prediction.
	always @(posedge clk) begin
		outcome_t w;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result with no query outstanding: %h %b", m_tdata, m_tuser);
				error_count++;
			end else begin
				w = pending_results.pop_front();
				hits_seen  += w.hit;
				degen_seen += w.degen;
				if (m_tuser[0] !== w.hit) begin
					$error("hit: expected %0d, got %0d", w.hit, m_tuser[0]);
					error_count++;
				end
				if (m_tuser[1] !== w.degen) begin
					$error("degenerate: expected %0d, got %0d", w.degen, m_tuser[1]);
					error_count++;
				end
				if (m_tdata[16:0] !== w.depth) begin
					$error("depth: expected %0d, got %0d", $signed(w.depth),
						$signed(m_tdata[16:0]));
					error_count++;
				end
				if (m_tdata[32:17] !== w.nx) begin
					$error("normal_x: expected %0d, got %0d", $signed(w.nx),
						$signed(m_tdata[32:17]));
					error_count++;
				end
				if (m_tdata[48:33] !== w.ny) begin
					$error("normal_y: expected %0d, got %0d", $signed(w.ny),
						$signed(m_tdata[48:33]));
					error_count++;
				end
				if (m_tdata[55:49] !== 7'd0) begin
					$error("pad bits: expected 0, got %h", m_tdata[55:49]);
					error_count++;
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Directed table: obvious cases carry their expected result.
	row_t directed[$];

	initial begin
		outcome_t none;
		outcome_t got;
		none = '{default: '0};
		// Centre deep inside a box: degenerate hit, depth is minus the radius.
		directed.push_back('{make_query(5 << 8, 5 << 8, 256, 0, 0, 10, 10), 1'b1,
			'{1'b1, 1'b1, 17'(-256), 16'd0, 16'd0}});
		// Zero radius on top of the box never hits.
		directed.push_back('{make_query(0, 0, 0, 0, 0, 10, 10), 1'b1, none});
		// Far away: no hit.
		directed.push_back('{make_query(-8388608, -8388608, 65535, 32767, 32767,
			32767, 32767), 1'b1, none});
		// Largest radius on an inside centre of the largest box.
		directed.push_back('{make_query(0, 0, 65535, -16384, -16384, 32767, 32767),
			1'b1, '{1'b1, 1'b1, 17'(-65535), 16'd0, 16'd0}});
		// Axis contacts from each side: normal of plus or minus one.
		directed.push_back('{make_query(-256, 128, 512, 0, 0, 1, 1), 1'b1,
			'{1'b1, 1'b0, 17'(-256), 16'd16384, 16'd0}});
		directed.push_back('{make_query(512, 128, 512, 0, 0, 1, 1), 1'b1,
			'{1'b1, 1'b0, 17'(-256), 16'(-16384), 16'd0}});
		directed.push_back('{make_query(128, -256, 512, 0, 0, 1, 1), 1'b1,
			'{1'b1, 1'b0, 17'(-256), 16'd0, 16'd16384}});
		directed.push_back('{make_query(128, 512, 512, 0, 0, 1, 1), 1'b1,
			'{1'b1, 1'b0, 17'(-256), 16'd0, 16'(-16384)}});
		// Touching exactly at the radius is not a hit.
		directed.push_back('{make_query(-512, 0, 512, 0, 0, 4, 4), 1'b1, none});
		// Hits just inside the radius: zero depth, then a depth of minus one.
		directed.push_back('{make_query(-9, -4, 10, 0, 0, 4, 4), 1'b0, none});
		directed.push_back('{make_query(-300, -300, 425, 0, 0, 4, 4), 1'b0, none});
		// Corner approaches, three of them to a zero-size box.
		directed.push_back('{make_query(-200, -100, 600, 0, 0, 0, 0), 1'b0, none});
		directed.push_back('{make_query(1100, 1500, 900, 0, 0, 4, 4), 1'b0, none});
		directed.push_back('{make_query(8388607, 8388607, 65535, 32767, 32767, 0, 0),
			1'b0, none});
		directed.push_back('{make_query(-8388608, 8388607, 65535, -32768, 32767, 0,
			0), 1'b0, none});
		// Centre on an edge: degenerate.
		directed.push_back('{make_query(0, 300, 100, 0, 0, 4, 4), 1'b1,
			'{1'b1, 1'b1, 17'(-100), 16'd0, 16'd0}});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].typed) begin
				got = collide(directed[i].q);
				if (got != directed[i].want) begin
					$error("directed row %0d: prediction disagrees with table", i);
					error_count++;
				end
			end
			send_query(directed[i].q);
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			// Long receiver hold-off while the sender keeps offering.
			if (n == 400)
				hold_long = 1'b1;
			// Sender pause until every result is back.
			if (n == 900) begin
				s_tvalid <= 1'b0;
				while (pending_results.size() != 0)
					@(posedge clk);
			end
			send_query(random_query());
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		$display("Covered %0d results: %0d hits, %0d with centre on the box.",
			results_seen, hits_seen, degen_seen);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/crc_pkg.sv
rtl/crc_front.sv
rtl/crc_isqrt.sv
rtl/crc_div.sv
rtl/circle_rect_collision.sv
rtl/crc_checker.sv
bench/tb_circle_rect_collision.sv
